FILE: sv/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none
package mexp_pkg;
    localparam int MOD_W = 31;
    localparam int VAL_W = 63;
    localparam int MUL_W = 2 * MOD_W;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [1:0] {
        DP_NOP    = 2'd0,
        DP_LOAD   = 2'd1,
        DP_REDUCE = 2'd2,
        DP_BIT    = 2'd3
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
    } t_dp_ctrl;

    typedef struct packed {
        logic busy;
        logic exp_zero;
        logic mod_small;
    } t_dp_stat;
endpackage
`default_nettype wire

FILE: sv/mexp_modred.sv
// Bit-serial reduction of a 63-bit value by the modulus, one bit per cycle.
`default_nettype none
module mexp_modred
    import mexp_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [VAL_W-1:0]  i_value,
    input  wire [MOD_W-1:0]  i_modulus,
    output logic             o_busy,
    output logic [MOD_W-1:0] o_rem
);
    logic [VAL_W-1:0] r_val;
    logic [MOD_W-1:0] r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [MOD_W:0]   n_sh;
    logic [MOD_W:0]   n_sub;

    always_comb begin
        n_sh  = {r_rem, r_val[VAL_W-1]};
        n_sub = n_sh - {1'b0, i_modulus};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(VAL_W - 1);
            r_val  <= i_value;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[VAL_W-2:0], 1'b0};
            r_rem <= n_sub[MOD_W] ? n_sh[MOD_W-1:0] : n_sub[MOD_W-1:0];
            if (r_cnt == '0) r_busy <= 1'b0;
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

FILE: sv/mexp_dp.sv
// Datapath: base reduction, multiply and square products with a shared reducer, exponent shifter.
`default_nettype none
module mexp_dp
    import mexp_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_dp_ctrl         i_ctrl,
    input  wire              i_op,
    input  wire [VAL_W-1:0]  i_base,
    input  wire [VAL_W-1:0]  i_exponent,
    input  wire [MOD_W-1:0]  i_modulus,
    output t_dp_stat         o_stat,
    output logic [MOD_W-1:0] o_result
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL_A, S_RED_A, S_MUL_S, S_RED_S
    } t_seq;

    t_seq             r_seq;
    logic [VAL_W-1:0] r_exp;
    logic [MOD_W-1:0] r_acc;
    logic [MOD_W-1:0] r_sq;
    logic [MUL_W-1:0] r_prod;
    logic             r_red_start;
    logic [VAL_W-1:0] n_red_in;
    logic             w_red_busy;
    logic [MOD_W-1:0] w_rem;
    logic             r_base_pend;

    assign n_red_in = r_base_pend ? i_base : {1'b0, r_prod};

    mexp_modred u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_red_start),
        .i_value   (n_red_in),
        .i_modulus (i_modulus),
        .o_busy    (w_red_busy),
        .o_rem     (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_red_start <= 1'b0;
            r_base_pend <= 1'b0;
        end else begin
            r_red_start <= 1'b0;
            case (r_seq)
                S_IDLE: begin
                    case (i_ctrl.cmd)
                        DP_LOAD: begin
                            r_exp <= i_op ? {32'd0, i_modulus - 31'd2} : i_exponent;
                            r_acc <= 31'd1;
                        end
                        DP_REDUCE: begin
                            r_base_pend <= 1'b1;
                            r_red_start <= 1'b1;
                            r_seq       <= S_RED_S;
                        end
                        DP_BIT: begin
                            r_seq <= S_MUL_A;
                        end
                        default: ;
                    endcase
                end
                S_MUL_A: begin
                    if (r_exp[0]) begin
                        r_prod      <= r_acc * r_sq;
                        r_red_start <= 1'b1;
                        r_seq       <= S_RED_A;
                    end else begin
                        r_seq <= S_MUL_S;
                    end
                end
                S_RED_A: begin
                    if (!r_red_start && !w_red_busy) begin
                        r_acc <= w_rem;
                        r_seq <= S_MUL_S;
                    end
                end
                S_MUL_S: begin
                    r_prod      <= r_sq * r_sq;
                    r_red_start <= 1'b1;
                    r_exp       <= {1'b0, r_exp[VAL_W-1:1]};
                    r_seq       <= S_RED_S;
                end
                S_RED_S: begin
                    if (!r_red_start && !w_red_busy) begin
                        r_sq        <= w_rem;
                        r_base_pend <= 1'b0;
                        r_seq       <= S_IDLE;
                    end
                end
                default: r_seq <= S_IDLE;
            endcase
        end
    end

    assign o_stat.busy      = (r_seq != S_IDLE);
    assign o_stat.exp_zero  = (r_exp == '0);
    assign o_stat.mod_small = (i_modulus < 31'd2);
    assign o_result         = o_stat.mod_small ? '0 : r_acc;
endmodule
`default_nettype wire

FILE: sv/mexp_ctrl.sv
// Controller: input/output handshake and sequencing of the datapath.
`default_nettype none
module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output logic     o_cap,
    output t_dp_ctrl o_ctrl,
    input  t_dp_stat i_stat
);
    typedef enum logic [2:0] {
        C_IDLE, C_LOAD, C_RED, C_WAIT, C_STEP, C_DONE
    } t_state;

    t_state  r_state;
    t_dp_cmd n_cmd;

    always_comb begin
        case (r_state)
            C_LOAD:  n_cmd = i_stat.mod_small ? DP_NOP : DP_REDUCE;
            C_STEP:  n_cmd = (!i_stat.busy && !i_stat.exp_zero) ? DP_BIT : DP_NOP;
            default: n_cmd = DP_NOP;
        endcase
        if (r_state == C_IDLE && i_in_valid) n_cmd = DP_LOAD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            case (r_state)
                C_IDLE: if (i_in_valid) r_state <= C_LOAD;
                C_LOAD: r_state <= i_stat.mod_small ? C_DONE : C_RED;
                C_RED:  r_state <= C_WAIT;
                C_WAIT: if (!i_stat.busy) r_state <= C_STEP;
                C_STEP: begin
                    if (!i_stat.busy) begin
                        if (i_stat.exp_zero) r_state <= C_DONE;
                        else                 r_state <= C_RED;
                    end
                end
                C_DONE: if (i_out_ready) r_state <= C_IDLE;
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_ctrl.cmd  = n_cmd;
    assign o_in_ready  = (r_state == C_IDLE);
    assign o_cap       = (r_state == C_IDLE) && i_in_valid;
    assign o_out_valid = (r_state == C_DONE);
endmodule
`default_nettype wire

FILE: sv/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Usage:
//   Slave stream s_axis: tdata = {exponent, base} (base in bits 62:0,
//   exponent in bits 125:63), tuser = op (0 power, 1 Fermat inverse).
//   Master stream m_axis: tdata = result in bits 30:0.
//   Config channel i_cfg_valid/o_cfg_ready/i_cfg_data writes the modulus;
//   write only while idle.
// Sequence: the base is reduced first, then per exponent bit up to two
//   products are formed, each reduced by the bit-serial reducer. One word
//   is worked on at a time.
// Reset: modulus returns to 1000000007, no word is held.
// Stall: the result is held on m_axis until taken; no new word is accepted
//   until then.
`default_nettype none
module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [127:0] s_axis_tdata,   // base[62:0], exponent[125:63]
    input  wire         s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result[30:0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [30:0]  i_cfg_data
);
    logic [MOD_W-1:0] r_modulus;
    logic [MOD_W-1:0] w_result;
    logic             w_cap;
    t_dp_ctrl         w_ctrl;
    t_dp_stat         w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_modulus <= MODULUS_RESET;
        else if (i_cfg_valid) r_modulus <= i_cfg_data;
    end

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cap       (w_cap),
        .o_ctrl      (w_ctrl),
        .i_stat      (w_stat)
    );

    logic [VAL_W-1:0] r_base;
    always_ff @(posedge i_clk) begin
        if (w_cap) r_base <= s_axis_tdata[VAL_W-1:0];
    end

    mexp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_op       (s_axis_tuser),
        .i_base     (r_base),
        .i_exponent (s_axis_tdata[2*VAL_W-1:VAL_W]),
        .i_modulus  (r_modulus),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    assign m_axis_tdata = {1'b0, w_result};
endmodule
`default_nettype wire

FILE: sv/mexp_checker.sv
// Port-level checker for the modular exponentiation block.
`default_nettype none
module mexp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
    a_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31])
        else $error("padding bit set");
endmodule

bind modular_exponentiation mexp_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: bench/tb_modular_exponentiation.sv
// Self-checking testbench for the modular exponentiation stream block.
`timescale 1ns / 100ps

class mexp_scoreboard;
    bit [30:0] modulus;
    bit [30:0] expected_results[$];
    int        fails;
    int        words_in;
    int        words_out;

    function new();
        modulus = mexp_pkg::MODULUS_RESET;
    endfunction

    function bit [30:0] power_mod(bit op, bit [62:0] b, bit [62:0] e);
        bit [63:0] m;
        bit [63:0] acc;
        bit [63:0] sq;
        bit [63:0] x;
        m = {33'd0, modulus};
        if (m < 2) return 31'd0;
        x = op ? m - 2 : {1'b0, e};
        acc = 1;
        sq = {1'b0, b} % m;
        while (x != 0) begin
            if (x[0]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            x = x >> 1;
        end
        return acc[30:0];
    endfunction

    function void note_word(bit op, bit [62:0] b, bit [62:0] e);
        expected_results.insert(expected_results.size(), power_mod(op, b, e));
        words_in++;
    endfunction

    function void check_word(bit [30:0] got);
        bit [30:0] want;
        words_out++;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d", $time, got);
            fails++;
            return;
        end
        want = expected_results.pop_front();
        if (got !== want) begin
            $display("%0t: result mismatch: expected %0d, actual %0d", $time, want, got);
            fails++;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam bit OP_POWER   = 1'b0;
    localparam bit OP_INVERSE = 1'b1;
    localparam int LIMIT      = 6000000;
    localparam int LONG_HOLD  = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;     // base[62:0], exponent[125:63]
    logic         s_axis_tuser;     // op
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;     // result[30:0]
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [30:0]  i_cfg_data;

    mexp_scoreboard sb;
    int  cycles;
    int  cfg_writes;
    bit  burst;
    bit  hold_req;

    modular_exponentiation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function bit [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    // small exponents mostly, full width now and then
    function bit [62:0] rand_exponent();
        bit [62:0] v;
        v = rand63();
        if ($urandom_range(0, 15) != 0) v = v >> $urandom_range(50, 62);
        return v;
    endfunction

    task automatic send_word(bit op, bit [62:0] b, bit [62:0] e);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, e, b};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, b, e);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_modulus(bit [30:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.modulus = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_words(int n);
        bit op;
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(0, 3) == 0) ? OP_INVERSE : OP_POWER;
            burst = (k % 10) >= 7;
            send_word(op, ($urandom_range(0, 3) == 0) ? 63'($urandom_range(0, 20)) : rand63(),
                      rand_exponent());
        end
        burst = 1'b0;
    endtask

    // receiver: random stalls, one long hold on request
    initial begin
        int n;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            n = burst ? 0 : $urandom_range(0, 8);
            if (hold_req) begin
                n = LONG_HOLD;
                hold_req = 1'b0;
            end
            @(negedge i_clk);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata[30:0]);
        end
    end

    initial begin
        bit [30:0] moduli[6];
        sb = new();
        cycles = 0;
        cfg_writes = 0;
        burst = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_POWER;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset modulus
        send_word(OP_POWER, 63'd0, 63'd0);
        send_word(OP_POWER, 63'd5, 63'd0);
        send_word(OP_POWER, 63'd0, 63'd5);
        send_word(OP_POWER, 63'd7, 63'd1);
        send_word(OP_POWER, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
        send_word(OP_POWER, 63'd1000000007, 63'd3);
        send_word(OP_POWER, 63'd1000000006, 63'd2);
        send_word(OP_INVERSE, 63'd2, 63'd0);
        send_word(OP_INVERSE, 63'd0, 63'h7FFF_FFFF_FFFF_FFFF);
        send_word(OP_INVERSE, 63'h7FFF_FFFF_FFFF_FFFF, 63'd9);
        // pause until every result is back
        drain();
        random_words(16);

        write_modulus(31'd2);
        send_word(OP_INVERSE, 63'd0, 63'd12);
        send_word(OP_INVERSE, 63'd3, 63'd12);
        send_word(OP_POWER, 63'd4, 63'd0);
        random_words(10);

        write_modulus(31'h7FFF_FFFF);
        send_word(OP_POWER, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
        send_word(OP_INVERSE, 63'd12345, 63'd0);
        send_word(OP_POWER, 63'h7FFF_FFFE, 63'd2);
        random_words(14);

        write_modulus(31'd13);
        hold_req = 1'b1;
        random_words(20);

        write_modulus(31'd1);
        send_word(OP_POWER, 63'd5, 63'd0);
        send_word(OP_INVERSE, 63'd5, 63'd3);
        random_words(6);

        write_modulus(31'd0);
        send_word(OP_POWER, 63'd0, 63'd0);
        send_word(OP_INVERSE, 63'h7FFF_FFFF_FFFF_FFFF, 63'd1);
        random_words(6);

        moduli[0] = 31'($urandom_range(2, 32'h7FFF_FFFF));
        moduli[1] = 31'd65537;
        moduli[2] = 31'd4;
        for (int p = 0; p < 3; p++) begin
            write_modulus(moduli[p]);
            random_words(14);
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Ran %0d words over %0d modulus writes, %0d results checked, %0d mismatches.",
                 sb.words_in, cfg_writes, sb.words_out, sb.fails);
        $display("Covered power and inverse, zero exponent, moduli 0, 1, 2 and 2^31-1.");
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: modular_exponentiation.f
sv/mexp_pkg.sv
sv/mexp_modred.sv
sv/mexp_dp.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
bench/tb_modular_exponentiation.sv
